// ----- hw/rtl/hce_pkg.sv -----
// Shared types and constants for the Huffman code table encoder.
package hce_pkg;

    localparam int BYTE_W = 8;
    localparam int PEND_W = 7;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_req;

    // lookup stage status handed to the packer
    typedef struct packed {
        logic       valid;
        logic [1:0] mode;
        logic       hit;
    } t_s1_ctl;

endpackage

// ----- hw/rtl/hce_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module hce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/hce_table.sv -----
// Code table: entry formatting, per-entry valid bits and the table RAM.
module hce_table #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic                                 i_rd_en,
    input  logic [$clog2(SYMBOL_COUNT)-1:0]      i_addr,
    input  logic [31:0]                          i_code_bits,
    input  logic [5:0]                           i_code_length,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0]    o_rd_len,
    output logic [MAX_CODE_LEN-1:0]              o_rd_code,
    output logic                                 o_rd_hit
);

    localparam int CW = MAX_CODE_LEN;
    localparam int LW = $clog2(CW + 1);
    localparam logic [6:0] LEN_CAP = 7'(CW);

    logic [CW+31:0]           code_wide;
    logic [6:0]               len_in;
    logic [6:0]               len_sat;
    logic [CW-1:0]            code_mask;
    logic [CW+LW-1:0]         wr_data;
    logic [CW+LW-1:0]         rd_data;
    logic [SYMBOL_COUNT-1:0]  r_vld;
    logic                     r_hit;

    // saturate the length, drop codeword bits at or above it
    assign code_wide = {{CW{1'b0}}, i_code_bits};
    assign len_in    = {1'b0, i_code_length};
    assign len_sat   = (len_in > LEN_CAP) ? LEN_CAP : len_in;
    assign code_mask = ~({CW{1'b1}} << len_sat);
    assign wr_data   = {LW'(len_sat), code_wide[CW-1:0] & code_mask};

    hce_ram #(
        .WIDTH (CW + LW),
        .DEPTH (SYMBOL_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_addr),
        .o_rd_data (rd_data)
    );

    // an entry never loaded since reset reads as an empty code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit <= r_vld[i_addr];
            end
        end
    end

    assign o_rd_len  = rd_data[CW+LW-1:CW];
    assign o_rd_code = rd_data[CW-1:0];
    assign o_rd_hit  = r_hit;

endmodule

// ----- hw/rtl/hce_pack.sv -----
// Bit packer: pending-bit accumulator and byte emitter.
module hce_pack #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hce_pkg::t_s1_ctl                  i_s1,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0] i_len,
    input  logic [MAX_CODE_LEN-1:0]           i_code,
    input  logic                              i_out_stall,
    output logic                              o_s1_go,
    output logic                              o_out_valid,
    output hce_pkg::t_out_req                 o_out
);

    import hce_pkg::*;

    localparam int CW     = MAX_CODE_LEN;
    localparam int LW     = $clog2(CW + 1);
    localparam int ACC_W  = CW + PEND_W;
    localparam int TW     = $clog2(ACC_W + 1);
    localparam int NB_MAX = ACC_W / BYTE_W;
    localparam int CNTW   = $clog2(NB_MAX + 1);

    logic [PEND_W-1:0] r_pend, n_pend;
    logic [2:0]        r_pcnt, n_pcnt;
    logic [ACC_W-1:0]  r_word, n_word;
    logic [CNTW-1:0]   r_left, n_left;

    logic [LW-1:0]     eff_len;
    logic [ACC_W-1:0]  acc;
    logic [TW-1:0]     total;
    logic [2:0]        rem;
    logic [ACC_W-1:0]  word_enc;
    logic [BYTE_W-1:0] fl_byte;
    logic [ACC_W-1:0]  job_word;
    logic [CNTW-1:0]   job_n;
    logic [PEND_W-1:0] job_pend;
    logic [2:0]        job_pcnt;
    logic              out_acc;
    logic              em_free;

    // append codeword below the pending bits
    assign eff_len  = i_s1.hit ? i_len : '0;
    assign acc      = (ACC_W'(r_pend) << eff_len) | ACC_W'(i_s1.hit ? i_code : '0);
    assign total    = TW'(r_pcnt) + TW'(eff_len);
    assign rem      = total[2:0];
    assign word_enc = acc << (TW'(ACC_W) - total);
    assign fl_byte  = {r_pend, 1'b0} << (3'(PEND_W) - r_pcnt);

    always_comb begin
        job_word = word_enc;
        job_n    = '0;
        job_pend = r_pend;
        job_pcnt = r_pcnt;
        case (i_s1.mode)
            MODE_ENCODE: begin
                job_n    = CNTW'(total >> 3);
                job_pend = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
                job_pcnt = rem;
            end
            MODE_FLUSH: begin
                job_word = {fl_byte, {(ACC_W-BYTE_W){1'b0}}};
                job_n    = (r_pcnt != 3'd0) ? CNTW'(1) : '0;
                job_pend = '0;
                job_pcnt = 3'd0;
            end
            default: begin
            end
        endcase
    end

    assign out_acc = o_out_valid && !i_out_stall;
    assign em_free = (r_left == '0) || ((r_left == CNTW'(1)) && out_acc);
    assign o_s1_go = i_s1.valid && ((job_n == '0) || em_free);

    always_comb begin
        n_pend = r_pend;
        n_pcnt = r_pcnt;
        n_word = r_word;
        n_left = r_left;
        if (o_s1_go) begin
            n_pend = job_pend;
            n_pcnt = job_pcnt;
        end
        if (o_s1_go && (job_n != '0)) begin
            n_word = job_word;
            n_left = job_n;
        end else if (out_acc) begin
            n_word = r_word << BYTE_W;
            n_left = r_left - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pcnt <= 3'd0;
            r_left <= '0;
        end else begin
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
            r_left <= n_left;
        end
        r_word <= n_word;
    end

    assign o_out_valid       = (r_left != '0);
    assign o_out.out_byte    = r_word[ACC_W-1 -: BYTE_W];
    assign o_out.last_of_run = (r_left == CNTW'(1));

`ifndef SYNTH
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CNTW'(NB_MAX))
        else $error("byte count above maximum");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s1_go && (i_s1.mode == MODE_FLUSH)) |=> (r_pcnt == 3'd0))
        else $error("flush left pending bits");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.last_of_run && !(o_s1_go && (job_n != '0)))
        |=> !o_out_valid)
        else $error("bytes shown past end of run");
`endif

endmodule

// ----- hw/rtl/huffman_code_table_encoder_top.sv -----
// Top level of the Huffman code table encoder: handshakes and lookup stage.
//
//  channel  | signals                          | direction | content
//  ---------+----------------------------------+-----------+----------------------
//  in       | i_in_valid, o_in_stall, i_in_req | sink      | load / encode / flush
//  out      | o_out_valid, i_out_stall, o_out  | source    | packed byte + last
//
// An item is accepted each cycle unless the input is stalled; loads write the table RAM at acceptance,
// encodes read it and see the result in the next cycle in the lookup stage.
// An item yielding N bytes holds the emitter until all N are taken (N up to
// (MAX_CODE_LEN+7)/8); an item with bytes waits there until the emitter
// is free, items without bytes pass straight through.
// Reset clears all table valid bits together; no sweep, no bring-up delay.
// A stalled output stalls the input only once the lookup stage is blocked.
module huffman_code_table_encoder_top #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  hce_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hce_pkg::t_out_req o_out
);

    import hce_pkg::*;

    localparam int AW = $clog2(SYMBOL_COUNT);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam logic [8:0] SYM_LIM = 9'(SYMBOL_COUNT);

    logic                    in_acc;
    logic                    in_range;
    logic                    tbl_wr;
    logic                    tbl_rd;
    logic [LW-1:0]           rd_len;
    logic [MAX_CODE_LEN-1:0] rd_code;
    logic                    rd_hit;
    logic                    s1_go;
    t_s1_ctl                 s1_ctl;

    // lookup stage control
    logic       r_s1_valid, n_s1_valid;
    logic [1:0] r_s1_mode;
    logic       r_s1_inr;

    assign in_range   = ({1'b0, i_in_req.symbol} < SYM_LIM);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign tbl_wr     = in_acc && (i_in_req.mode == MODE_LOAD) && in_range;
    assign tbl_rd     = in_acc && (i_in_req.mode == MODE_ENCODE);

    hce_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (tbl_wr),
        .i_rd_en       (tbl_rd),
        .i_addr        (i_in_req.symbol[AW-1:0]),
        .i_code_bits   (i_in_req.code_bits),
        .i_code_length (i_in_req.code_length),
        .o_rd_len      (rd_len),
        .o_rd_code     (rd_code),
        .o_rd_hit      (rd_hit)
    );

    // out-of-range symbol behaves as an empty code
    assign s1_ctl.valid = r_s1_valid;
    assign s1_ctl.mode  = r_s1_mode;
    assign s1_ctl.hit   = rd_hit && r_s1_inr;

    hce_pack #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (s1_ctl),
        .i_len       (rd_len),
        .i_code      (rd_code),
        .i_out_stall (i_out_stall),
        .o_s1_go     (s1_go),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
        if (in_acc) begin
            r_s1_mode <= i_in_req.mode;
            r_s1_inr  <= in_range;
        end
    end

`ifndef SYNTH
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty lookup stage");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_s1_valid) |-> s1_go)
        else $error("lookup stage overwritten");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tbl_wr && tbl_rd))
        else $error("table read and write in one cycle");
`endif

endmodule
